// ----- rtl/pixel_format_converter_defines.svh -----
// ---------------------------------------------------------------------------
// pixel format converter assertion macros
// shared checks for the converter pipeline stages
// ---------------------------------------------------------------------------
`ifndef PIXEL_FORMAT_CONVERTER_DEFINES_SVH
`define PIXEL_FORMAT_CONVERTER_DEFINES_SVH

// check that is suspended while reset is asserted
`define PFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that also holds during reset
`define PFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/pfc_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfc_pkg
// types and codes shared by the pixel format converter pipeline
// ---------------------------------------------------------------------------
package pfc_pkg;

  localparam int unsigned PixelW  = 32;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 4;

  // pixel format codes, codes nine and up pass through
  typedef enum logic [3:0] {
    FMT_COPY32   = 4'd0,
    FMT_ARGB4444 = 4'd1,
    FMT_RGB565   = 4'd2,
    FMT_XRGB1555 = 4'd3,
    FMT_ARGB1555 = 4'd4,
    FMT_RGB888   = 4'd5,
    FMT_L8       = 4'd6,
    FMT_A8L8     = 4'd7,
    FMT_A8       = 4'd8
  } pfc_fmt_e;

  // conversion direction
  typedef enum logic {
    DIR_EXPAND = 1'b0,
    DIR_REDUCE = 1'b1
  } pfc_dir_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PIXEL_FORMAT = 2'd0,
    REG_DIRECTION    = 2'd1
  } pfc_reg_e;

  // configuration seen by the channel split and pack stages
  typedef struct packed {
    pfc_fmt_e fmt;
    pfc_dir_e dir;
  } pfc_cfg_t;

  // input item
  typedef struct packed {
    logic [PixelW-1:0] pixel_in;
    logic              row_end_in;
  } pfc_in_t;

  // result item
  typedef struct packed {
    logic [PixelW-1:0] pixel_out;
    logic              row_end_out;
  } pfc_out_t;

  // channels split out of a pixel, right aligned raw fields
  typedef struct packed {
    logic [ChanW-1:0] a;
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
    logic             row_end;
  } pfc_chan_t;

endpackage

// ----- rtl/pixel_format_converter.sv -----
`timescale 1ns / 1ps
// path: each pixel passes the input, channel split and output registers in order
// throughput: one pixel per cycle, set by three register stages that each advance
//   whenever the stage after them can take data
// reset: valid bits cleared, pixel_format resets to copy32 and direction to expand
// ---------------------------------------------------------------------------
// pixel_format_converter
// converts pixels between a configured format and ARGB8888 in a three stage pipe
// ---------------------------------------------------------------------------
`include "pixel_format_converter_defines.svh"

module pixel_format_converter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pfc_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [pfc_pkg::CfgDatW-1:0]         cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  pfc_pkg::pfc_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output pfc_pkg::pfc_out_t                   out_data_o
);
  import pfc_pkg::*;

  pfc_fmt_e  fmt_q;
  pfc_dir_e  dir_q;
  pfc_cfg_t  cfg;
  logic      in_valid_q;
  pfc_in_t   in_data_q;
  logic      unp_stall;
  logic      unp_valid;
  pfc_chan_t unp_data;
  logic      pack_stall;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_COPY32;
      dir_q <= DIR_EXPAND;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PIXEL_FORMAT: fmt_q <= pfc_fmt_e'(cfg_wdata_i);
        REG_DIRECTION:    dir_q <= pfc_dir_e'(cfg_wdata_i[0]);
        default: begin
        end
      endcase
    end
  end

  assign cfg.fmt = fmt_q;
  assign cfg.dir = dir_q;

  // input register stage
  assign in_stall_o = in_valid_q & unp_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
  end

  // channel split stage
  pfc_unpack u_unpack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (in_valid_q),
    .stall_o (unp_stall),
    .data_i  (in_data_q),
    .valid_o (unp_valid),
    .stall_i (pack_stall),
    .data_o  (unp_data)
  );

  // scale, pack and output register stage
  pfc_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (unp_valid),
    .stall_o (pack_stall),
    .data_i  (unp_data),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

  // back pressure only originates at the output
  `PFC_ASSERT_ALWAYS(a_stall_origin, in_stall_o |-> (out_stall_i && out_valid_o), "input stalled without output stall")
  `PFC_ASSERT(a_full_pipe, in_stall_o |-> (in_valid_q && unp_valid), "input stalled with a bubble in the pipe")
  `PFC_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)), "stalled result changed")

endmodule

// ----- rtl/pfc_unpack.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfc_unpack
// pipeline stage that splits a pixel into raw channel fields
// ---------------------------------------------------------------------------
module pfc_unpack (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfc_pkg::pfc_cfg_t  cfg_i,
  input  logic               valid_i,
  output logic               stall_o,
  input  pfc_pkg::pfc_in_t   data_i,
  output logic               valid_o,
  input  logic               stall_i,
  output pfc_pkg::pfc_chan_t data_o
);
  import pfc_pkg::*;

  logic      valid_q;
  pfc_chan_t chan_d;
  pfc_chan_t chan_q;
  logic      load;

  // stage holds only while full and blocked downstream
  assign stall_o = valid_q & stall_i;
  assign load    = valid_i & ~stall_o;

  // field extraction
  always_comb begin
    logic [PixelW-1:0] p;
    p = data_i.pixel_in;
    chan_d.a       = p[31:24];
    chan_d.r       = p[23:16];
    chan_d.g       = p[15:8];
    chan_d.b       = p[7:0];
    chan_d.row_end = data_i.row_end_in;
    if (cfg_i.dir == DIR_EXPAND) begin
      case (cfg_i.fmt)
        FMT_ARGB4444: begin
          chan_d.a = {4'd0, p[15:12]};
          chan_d.r = {4'd0, p[11:8]};
          chan_d.g = {4'd0, p[7:4]};
          chan_d.b = {4'd0, p[3:0]};
        end
        FMT_RGB565: begin
          chan_d.a = 8'hFF;
          chan_d.r = {3'd0, p[15:11]};
          chan_d.g = {2'd0, p[10:5]};
          chan_d.b = {3'd0, p[4:0]};
        end
        FMT_XRGB1555, FMT_ARGB1555: begin
          chan_d.a = (cfg_i.fmt == FMT_ARGB1555) ? {ChanW{p[15]}} : 8'hFF;
          chan_d.r = {3'd0, p[14:10]};
          chan_d.g = {3'd0, p[9:5]};
          chan_d.b = {3'd0, p[4:0]};
        end
        FMT_RGB888: begin
          chan_d.a = 8'hFF;
        end
        FMT_L8: begin
          chan_d.a = 8'hFF;
          chan_d.r = p[7:0];
          chan_d.g = p[7:0];
        end
        FMT_A8L8: begin
          chan_d.a = p[15:8];
          chan_d.r = p[7:0];
          chan_d.g = p[7:0];
        end
        FMT_A8: begin
          chan_d.a = p[7:0];
          chan_d.r = 8'hFF;
          chan_d.g = 8'hFF;
          chan_d.b = 8'hFF;
        end
        default: begin
        end
      endcase
    end else begin
      // truncation to the top bits of each channel
      case (cfg_i.fmt)
        FMT_ARGB4444: begin
          chan_d.a = {4'd0, p[31:28]};
          chan_d.r = {4'd0, p[23:20]};
          chan_d.g = {4'd0, p[15:12]};
          chan_d.b = {4'd0, p[7:4]};
        end
        FMT_RGB565: begin
          chan_d.a = '0;
          chan_d.r = {3'd0, p[23:19]};
          chan_d.g = {2'd0, p[15:10]};
          chan_d.b = {3'd0, p[7:3]};
        end
        FMT_XRGB1555, FMT_ARGB1555: begin
          chan_d.a = {7'd0, p[31]};
          chan_d.r = {3'd0, p[23:19]};
          chan_d.g = {3'd0, p[15:11]};
          chan_d.b = {3'd0, p[7:3]};
        end
        FMT_RGB888: begin
          chan_d.a = '0;
        end
        FMT_L8: begin
          chan_d.a = '0;
          chan_d.g = '0;
          chan_d.b = '0;
        end
        FMT_A8L8, FMT_A8: begin
          chan_d.g = '0;
          chan_d.b = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      chan_q <= chan_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = chan_q;

endmodule

// ----- rtl/pfc_pack.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfc_pack
// output stage that scales channels and packs the result pixel
// ---------------------------------------------------------------------------
`include "pixel_format_converter_defines.svh"

module pfc_pack (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfc_pkg::pfc_cfg_t  cfg_i,
  input  logic               valid_i,
  output logic               stall_o,
  input  pfc_pkg::pfc_chan_t data_i,
  output logic               valid_o,
  input  logic               stall_i,
  output pfc_pkg::pfc_out_t  data_o
);
  import pfc_pkg::*;

  logic     valid_q;
  pfc_out_t out_d;
  pfc_out_t out_q;
  logic     load;

  // five bit channel replicated up to eight bits
  function automatic logic [ChanW-1:0] rep5(input logic [ChanW-1:0] x);
    return {x[4:0], x[4:2]};
  endfunction

  // six bit channel replicated up to eight bits
  function automatic logic [ChanW-1:0] rep6(input logic [ChanW-1:0] x);
    return {x[5:0], x[5:4]};
  endfunction

  // four bit channel times 17
  function automatic logic [ChanW-1:0] mul17(input logic [ChanW-1:0] x);
    return {x[3:0], x[3:0]};
  endfunction

  assign stall_o = valid_q & stall_i;
  assign load    = valid_i & ~stall_o;

  // scaling and packing
  always_comb begin
    pfc_chan_t c;
    c = data_i;
    out_d.row_end_out = c.row_end;
    out_d.pixel_out   = {c.a, c.r, c.g, c.b};
    if (cfg_i.dir == DIR_EXPAND) begin
      case (cfg_i.fmt)
        FMT_ARGB4444: begin
          out_d.pixel_out = {mul17(c.a), mul17(c.r), mul17(c.g), mul17(c.b)};
        end
        FMT_RGB565: begin
          out_d.pixel_out = {c.a, rep5(c.r), rep6(c.g), rep5(c.b)};
        end
        FMT_XRGB1555, FMT_ARGB1555: begin
          out_d.pixel_out = {c.a, rep5(c.r), rep5(c.g), rep5(c.b)};
        end
        default: begin
        end
      endcase
    end else begin
      case (cfg_i.fmt)
        FMT_ARGB4444: begin
          out_d.pixel_out = {16'd0, c.a[3:0], c.r[3:0], c.g[3:0], c.b[3:0]};
        end
        FMT_RGB565: begin
          out_d.pixel_out = {16'd0, c.r[4:0], c.g[5:0], c.b[4:0]};
        end
        FMT_XRGB1555, FMT_ARGB1555: begin
          out_d.pixel_out = {16'd0, c.a[0], c.r[4:0], c.g[4:0], c.b[4:0]};
        end
        FMT_RGB888: begin
          out_d.pixel_out = {8'd0, c.r, c.g, c.b};
        end
        FMT_L8: begin
          out_d.pixel_out = {24'd0, c.r};
        end
        FMT_A8L8: begin
          out_d.pixel_out = {16'd0, c.a, c.r};
        end
        FMT_A8: begin
          out_d.pixel_out = {24'd0, c.a};
        end
        default: begin
        end
      endcase
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = out_q;

  // stage bookkeeping checks
  `PFC_ASSERT(a_load_fills, (valid_i && !stall_o) |=> valid_o, "loaded item not held in output stage")
  `PFC_ASSERT(a_drain_empties, (valid_o && !stall_i && !valid_i) |=> !valid_o, "transfer did not empty output stage")
  `PFC_ASSERT_ALWAYS(a_stall_when_full, stall_o |-> valid_o, "output stage stalls while empty")

endmodule

// ----- tb/sv/pixel_format_converter_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pixel_format_converter_test
// drives pixels through the converter under every format and direction and
// checks each result against a table row or convert_pixel; directed corner
// pixels first, then random rows with random sender and receiver idling
// ---------------------------------------------------------------------------
module pixel_format_converter_test;
  import pfc_pkg::*;

  localparam int PipeDepth = 3;
  localparam int SettleCycles = PipeDepth + 4;
  localparam int HoldCycles = 200;
  localparam int CycleLimit = 200000;
  localparam int SettingsPerMode = 8;
  localparam int DirectedRows = 26;

  // format codes without a conversion, passed through unchanged
  localparam logic [3:0] FmtUnknownLo = 4'd9;
  localparam logic [3:0] FmtUnknownHi = 4'd15;

  // one row of the directed stimulus table
  typedef struct {
    logic [3:0]  fmt;
    pfc_dir_e    dir;
    logic [31:0] pixel;
    logic        row_end;
    bit          known;
    logic [31:0] result;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  pfc_reg_e  cfg_index = REG_PIXEL_FORMAT;
  logic [CfgDatW-1:0] cfg_wdata = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  pfc_in_t   in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  pfc_out_t  out_data;

  pfc_out_t    pending_pixels[$];
  logic [3:0]  cur_fmt = FMT_COPY32;
  pfc_dir_e    cur_dir = DIR_EXPAND;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          row_left = 0;

  stim_row_t directed_rows[DirectedRows] = '{
    '{FMT_COPY32,   DIR_EXPAND, 32'hDEADBEEF, 1'b0, 1'b1, 32'hDEADBEEF},
    '{FMT_COPY32,   DIR_EXPAND, 32'hFFFFFFFF, 1'b1, 1'b1, 32'hFFFFFFFF},
    '{FMT_ARGB4444, DIR_EXPAND, 32'h0000FFFF, 1'b0, 1'b1, 32'hFFFFFFFF},
    '{FMT_ARGB4444, DIR_EXPAND, 32'hFFFF0000, 1'b1, 1'b1, 32'h00000000},
    '{FMT_ARGB4444, DIR_EXPAND, 32'h00001234, 1'b0, 1'b0, 32'h0},
    '{FMT_RGB565,   DIR_EXPAND, 32'hFFFF0000, 1'b0, 1'b1, 32'hFF000000},
    '{FMT_RGB565,   DIR_EXPAND, 32'h0000F81F, 1'b1, 1'b0, 32'h0},
    '{FMT_XRGB1555, DIR_EXPAND, 32'h00008000, 1'b0, 1'b1, 32'hFF000000},
    '{FMT_XRGB1555, DIR_EXPAND, 32'h00007FFF, 1'b1, 1'b1, 32'hFFFFFFFF},
    '{FMT_ARGB1555, DIR_EXPAND, 32'h00008000, 1'b0, 1'b1, 32'hFF000000},
    '{FMT_ARGB1555, DIR_EXPAND, 32'hFFFF7FFF, 1'b1, 1'b1, 32'h00FFFFFF},
    '{FMT_RGB888,   DIR_EXPAND, 32'h12345678, 1'b0, 1'b1, 32'hFF345678},
    '{FMT_L8,       DIR_EXPAND, 32'hFFFFFF80, 1'b0, 1'b1, 32'hFF808080},
    '{FMT_A8L8,     DIR_EXPAND, 32'h0000C03F, 1'b1, 1'b1, 32'hC03F3F3F},
    '{FMT_A8,       DIR_EXPAND, 32'hFFFFFF00, 1'b0, 1'b1, 32'h00FFFFFF},
    '{FmtUnknownLo, DIR_EXPAND, 32'hA5A5A5A5, 1'b1, 1'b1, 32'hA5A5A5A5},
    '{FmtUnknownHi, DIR_REDUCE, 32'h5A5A5A5A, 1'b0, 1'b1, 32'h5A5A5A5A},
    '{FMT_ARGB4444, DIR_REDUCE, 32'hFFFFFFFF, 1'b0, 1'b1, 32'h0000FFFF},
    '{FMT_RGB565,   DIR_REDUCE, 32'h00FFFFFF, 1'b1, 1'b1, 32'h0000FFFF},
    '{FMT_XRGB1555, DIR_REDUCE, 32'h80000000, 1'b0, 1'b1, 32'h00008000},
    '{FMT_ARGB1555, DIR_REDUCE, 32'h7FFFFFFF, 1'b1, 1'b1, 32'h00007FFF},
    '{FMT_RGB888,   DIR_REDUCE, 32'hFFFFFFFF, 1'b0, 1'b1, 32'h00FFFFFF},
    '{FMT_L8,       DIR_REDUCE, 32'h00AB0000, 1'b0, 1'b1, 32'h000000AB},
    '{FMT_A8L8,     DIR_REDUCE, 32'hCD00EF12, 1'b1, 1'b1, 32'h0000CD00},
    '{FMT_A8,       DIR_REDUCE, 32'h7F123456, 1'b0, 1'b1, 32'h0000007F},
    '{FMT_RGB565,   DIR_REDUCE, 32'h12345678, 1'b1, 1'b0, 32'h0}
  };

  pixel_format_converter i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // bit replication of 5 and 6 bit channels up to 8 bits
  function automatic logic [7:0] widen5(logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // expected converted pixel for the given setting
  function automatic logic [31:0] convert_pixel(logic [3:0] fmt, pfc_dir_e dir,
                                                logic [31:0] p);
    logic [7:0] a, r, g, b, alpha;
    a = p[31:24];
    r = p[23:16];
    g = p[15:8];
    b = p[7:0];
    alpha = (fmt == FMT_ARGB1555) ? {8{p[15]}} : 8'hFF;
    if (dir == DIR_EXPAND) begin
      case (fmt)
        // a 4 bit channel times 17 is the nibble written twice
        FMT_ARGB4444: return {p[15:12], p[15:12], p[11:8], p[11:8],
                              p[7:4], p[7:4], p[3:0], p[3:0]};
        FMT_RGB565:   return {8'hFF, widen5(p[15:11]), widen6(p[10:5]), widen5(p[4:0])};
        FMT_XRGB1555,
        FMT_ARGB1555: return {alpha, widen5(p[14:10]), widen5(p[9:5]), widen5(p[4:0])};
        FMT_RGB888:   return {8'hFF, p[23:0]};
        FMT_L8:       return {8'hFF, b, b, b};
        FMT_A8L8:     return {g, b, b, b};
        FMT_A8:       return {b, 24'hFFFFFF};
        default:      return p;
      endcase
    end
    case (fmt)
      FMT_ARGB4444: return {16'h0, a[7:4], r[7:4], g[7:4], b[7:4]};
      FMT_RGB565:   return {16'h0, r[7:3], g[7:2], b[7:3]};
      FMT_XRGB1555,
      FMT_ARGB1555: return {16'h0, a[7], r[7:3], g[7:3], b[7:3]};
      FMT_RGB888:   return {8'h0, p[23:0]};
      FMT_L8:       return {24'h0, r};
      FMT_A8L8:     return {16'h0, a, r};
      FMT_A8:       return {24'h0, a};
      default:      return p;
    endcase
  endfunction

  // random pixel biased toward channel extremes and clean narrow sources
  function automatic logic [31:0] random_pixel();
    logic [31:0] p;
    case ($urandom_range(9))
      6, 7: p = {16'h0, 16'($urandom())};
      8, 9: begin
        for (int i = 0; i < 4; i++) begin
          case ($urandom_range(4))
            0: p[i*8 +: 8] = 8'h00;
            1: p[i*8 +: 8] = 8'hFF;
            2: p[i*8 +: 8] = 8'h80;
            3: p[i*8 +: 8] = 8'h7F;
            default: p[i*8 +: 8] = 8'($urandom());
          endcase
        end
      end
      default: p = $urandom();
    endcase
    return p;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %08h want %08h at cycle %0d",
             what, got, want, cycle_count);
    mismatch_count++;
  endtask

  // register write, one cycle of write enable
  task automatic write_reg(pfc_reg_e idx, logic [CfgDatW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // stop offering pixels and wait until every result has come out
  task automatic settle_pipe();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic reconfigure(logic [3:0] fmt, pfc_dir_e dir);
    settle_pipe();
    write_reg(REG_PIXEL_FORMAT, fmt);
    write_reg(REG_DIRECTION, {{(CfgDatW-1){1'b0}}, dir});
    cur_fmt = fmt;
    cur_dir = dir;
  endtask

  // offer one pixel, hold it until the transfer, then maybe idle
  task automatic send_pixel(logic [31:0] pix, logic re, bit known, logic [31:0] result);
    pfc_out_t want;
    in_valid <= 1'b1;
    in_data <= '{pixel_in: pix, row_end_in: re};
    do @(posedge clk); while (in_stall);
    want.pixel_out = known ? result : convert_pixel(cur_fmt, cur_dir, pix);
    want.row_end_out = re;
    pending_pixels.insert(pending_pixels.size(), want);
    if (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (int'($urandom_range(99)) < send_idle_pct);
    end
  endtask

  // random pixels in rows of random length, a few row flags flipped
  task automatic send_random_rows(int count);
    logic re;
    for (int i = 0; i < count; i++) begin
      if (row_left == 0) row_left = $urandom_range(1, 16);
      row_left--;
      re = (row_left == 0) ^ ($urandom_range(19) == 0);
      send_pixel(random_pixel(), re, 1'b0, 32'h0);
    end
  endtask

  // receiver stall, random or held off for a long stretch on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req = 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
    end
    out_stall <= (hold_left != 0) || (int'($urandom_range(99)) < recv_idle_pct);
  end

  // result check against the oldest expected pixel
  always @(posedge clk) begin : check_results
    pfc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        flag_mismatch("unexpected transfer", out_data.pixel_out, 32'h0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.pixel_out !== want.pixel_out)
          flag_mismatch("pixel_out", out_data.pixel_out, want.pixel_out);
        if (out_data.row_end_out !== want.row_end_out)
          flag_mismatch("row_end_out", 32'(out_data.row_end_out), 32'(want.row_end_out));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [3:0] fmt;
    pfc_dir_e   dir;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners, first rows run on the reset setting
    foreach (directed_rows[i]) begin
      if (directed_rows[i].fmt != cur_fmt || directed_rows[i].dir != cur_dir)
        reconfigure(directed_rows[i].fmt, directed_rows[i].dir);
      send_pixel(directed_rows[i].pixel, directed_rows[i].row_end,
                 directed_rows[i].known, directed_rows[i].result);
    end

    // random phases: sender light and receiver heavy, swapped, then none
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 14 : (mode == 1) ? 79 : 0;
      recv_idle_pct = (mode == 0) ? 79 : (mode == 1) ? 14 : 0;
      for (int s = 0; s < SettingsPerMode; s++) begin
        case (s)
          0: begin fmt = FmtUnknownHi; dir = DIR_REDUCE; end
          1: begin fmt = FMT_COPY32;   dir = DIR_EXPAND; end
          2: begin fmt = FMT_A8;       dir = DIR_REDUCE; end
          default: begin
            fmt = ($urandom_range(4) == 0) ? 4'($urandom_range(FmtUnknownLo, FmtUnknownHi))
                                           : 4'($urandom_range(FMT_COPY32, FMT_A8));
            dir = pfc_dir_e'($urandom_range(1));
          end
        endcase
        reconfigure(fmt, dir);
        // long receiver hold while pixels keep coming, fills the pipe
        if (s == 2) hold_req = 1'b1;
        send_random_rows($urandom_range(24, 44));
      end
    end

    settle_pipe();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/pfc_pkg.sv
rtl/pfc_unpack.sv
rtl/pfc_pack.sv
rtl/pixel_format_converter.sv
tb/sv/pixel_format_converter_test.sv
